>>> rtl/finger_gap_collision_check_defines.svh
// Assertion macros used by the finger gap collision check checker (fgc_checker).
// No dependencies.
`ifndef FINGER_GAP_COLLISION_CHECK_DEFINES_SVH
`define FINGER_GAP_COLLISION_CHECK_DEFINES_SVH

// same-cycle implication
`define FGC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fgc: assertion failed");

// next-cycle implication
`define FGC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fgc: assertion failed");

`endif

>>> rtl/fgc_pkg.sv
// Package for the finger gap collision check: sizes, codes, transaction type, slot mask.
// No dependencies.
package fgc_pkg;

   localparam int NUM_PLACEMENTS = 10;
   localparam int SLOTS          = 2 * NUM_PLACEMENTS;

   localparam int COORD_W  = 32;
   localparam int CFG_W    = 31;
   localparam int AXIS_W   = 2;
   localparam int SEL_W    = 5;
   localparam int ACTION_W = 2;
   localparam int FINGER_W = 20;
   localparam int HAND_W   = 10;
   localparam int BASE_W   = COORD_W + 1;
   // lateral offset relative to a slot edge, moves by one step per cell
   localparam int D_W      = COORD_W + 1 + $clog2(NUM_PLACEMENTS + 1);

   localparam int REQ_W    = 136;
   localparam int RSP_W    = 32;
   localparam int CSR_W    = 32;
   localparam int REG_IDX_W = 3;
   localparam int ADDR_W   = REG_IDX_W + 2;

   localparam logic [CFG_W-1:0]  RST_TINE_WIDTH     = CFG_W'(10486);
   localparam logic [CFG_W-1:0]  RST_PALM_DEPTH     = CFG_W'(62915);
   localparam logic [CFG_W-1:0]  RST_PLACEMENT_STEP = CFG_W'(11068);
   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic signed [SEL_W-1:0] SEL_ALL = -5'sd1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN = 2'd0,
      ACT_POINT = 2'd1,
      ACT_END   = 2'd2
   } action_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_TINE_WIDTH     = 3'd0,
      REG_PALM_DEPTH     = 3'd1,
      REG_PLACEMENT_STEP = 3'd2,
      REG_LATERAL_AXIS   = 3'd3,
      REG_FORWARD_AXIS   = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic                        valid;
      action_type                  kind;
      logic                        mark;
      logic signed [D_W-1:0]       dl;
      logic signed [D_W-1:0]       dr;
      logic [NUM_PLACEMENTS-1:0]   occ_l;
      logic [NUM_PLACEMENTS-1:0]   occ_r;
      logic                        collided;
      logic                        saw;
      logic signed [SEL_W-1:0]     chosen;
   } item_type;

   function automatic logic [SLOTS-1:0] considered_mask(input logic signed [SEL_W-1:0] sel);
      logic [SLOTS-1:0] m;
      int c;
      m = '0;
      c = int'(sel);
      if (sel == SEL_ALL) begin
         m = '1;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (i == c || i == NUM_PLACEMENTS + c) begin
               m[i] = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

>>> rtl/finger_gap_collision_check.sv
// A result appears on rsp_tvalid once its end transaction has passed the cell
// registers of the chain and then the output register; one cell per slot pair.
// Throughput: one transaction per cycle; the whole chain advances together and
// holds only while a result waits in the output register and is not taken.
// Reset (synchronous): registers to defaults, slots free, all-slot selection.
// Top level; depends on fgc_pkg, fgc_front and fgc_cell.
module finger_gap_collision_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // coord_x[31:0], coord_y[63:32], coord_z[95:64], bite_depth[127:96],
   // slot_select[132:128], zero pad
   input  logic [fgc_pkg::REQ_W-1:0]      req_tdata,
   // action[1:0]
   input  logic [fgc_pkg::ACTION_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // finger_free[19:0], hand_free[29:20], base_collision[30], empty_region[31]
   output logic [fgc_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fgc_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [fgc_pkg::CSR_W-1:0]      csr_pwdata,
   output logic [fgc_pkg::CSR_W-1:0]      csr_prdata,
   output logic                          csr_pready
);
   import fgc_pkg::*;

   logic [CFG_W-1:0]  tine_width_ff, palm_depth_ff, placement_step_ff;
   logic [AXIS_W-1:0] lateral_axis_ff, forward_axis_ff;
   logic              csr_write;
   logic [REG_IDX_W-1:0] reg_idx;

   logic              en, accept;
   item_type          link [0:NUM_PLACEMENTS];
   item_type          tail;

   logic [SLOTS-1:0]          occ_all, free_all;
   logic [NUM_PLACEMENTS-1:0] hands;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FINGER_W-1:0]       finger_ff, finger_in;
   logic [HAND_W-1:0]         hand_ff, hand_in;
   logic                      basecol_ff, empty_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tine_width_ff     <= RST_TINE_WIDTH;
         palm_depth_ff     <= RST_PALM_DEPTH;
         placement_step_ff <= RST_PLACEMENT_STEP;
         lateral_axis_ff   <= AXIS_Y;
         forward_axis_ff   <= AXIS_X;
      end else if (csr_write) begin
         case (reg_idx)
            REG_TINE_WIDTH:     tine_width_ff     <= csr_pwdata[CFG_W-1:0];
            REG_PALM_DEPTH:     palm_depth_ff     <= csr_pwdata[CFG_W-1:0];
            REG_PLACEMENT_STEP: placement_step_ff <= csr_pwdata[CFG_W-1:0];
            REG_LATERAL_AXIS:   lateral_axis_ff   <= csr_pwdata[AXIS_W-1:0];
            REG_FORWARD_AXIS:   forward_axis_ff   <= csr_pwdata[AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TINE_WIDTH:     csr_prdata = CSR_W'(tine_width_ff);
         REG_PALM_DEPTH:     csr_prdata = CSR_W'(palm_depth_ff);
         REG_PLACEMENT_STEP: csr_prdata = CSR_W'(placement_step_ff);
         REG_LATERAL_AXIS:   csr_prdata = CSR_W'(lateral_axis_ff);
         REG_FORWARD_AXIS:   csr_prdata = CSR_W'(forward_axis_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // stream control
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && req_tready;

   fgc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_tuser),
      .coord_x      (req_tdata[COORD_W-1:0]),
      .coord_y      (req_tdata[2*COORD_W-1:COORD_W]),
      .coord_z      (req_tdata[3*COORD_W-1:2*COORD_W]),
      .bite_depth   (req_tdata[4*COORD_W-1:3*COORD_W]),
      .slot_select  (req_tdata[4*COORD_W+SEL_W-1:4*COORD_W]),
      .palm_depth   (palm_depth_ff),
      .lateral_axis (lateral_axis_ff),
      .forward_axis (forward_axis_ff),
      .item_out     (link[0])
   );

   for (genvar k = 0; k < NUM_PLACEMENTS; k++) begin : g_cell
      fgc_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .en             (en),
         .tine_width     (tine_width_ff),
         .placement_step (placement_step_ff),
         .item_in        (link[k]),
         .item_out       (link[k+1])
      );
   end

   assign tail = link[NUM_PLACEMENTS];

   // result assembly at the chain exit
   always_comb begin
      occ_all  = {tail.occ_r, tail.occ_l};
      free_all = '0;
      if (!tail.collided && tail.saw) begin
         free_all = ~occ_all & considered_mask(tail.chosen);
      end
      for (int i = 0; i < NUM_PLACEMENTS; i++) begin
         hands[i] = free_all[i] && free_all[NUM_PLACEMENTS+i];
      end
      finger_in    = FINGER_W'(free_all);
      hand_in      = HAND_W'(hands);
      rsp_valid_in = tail.valid && (tail.kind == ACT_END);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && rsp_valid_in) begin
         finger_ff  <= finger_in;
         hand_ff    <= hand_in;
         basecol_ff <= tail.collided;
         empty_ff   <= !tail.saw;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {empty_ff, basecol_ff, hand_ff, finger_ff};

endmodule

>>> rtl/fgc_front.sv
// Entry stage: axis selection, crop and base tests, per-evaluation state.
// Depends on fgc_pkg.
module fgc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [fgc_pkg::ACTION_W-1:0]      action,
   input  logic signed [fgc_pkg::COORD_W-1:0] coord_x,
   input  logic signed [fgc_pkg::COORD_W-1:0] coord_y,
   input  logic signed [fgc_pkg::COORD_W-1:0] coord_z,
   input  logic signed [fgc_pkg::COORD_W-1:0] bite_depth,
   input  logic signed [fgc_pkg::SEL_W-1:0]   slot_select,
   input  logic [fgc_pkg::CFG_W-1:0]          palm_depth,
   input  logic [fgc_pkg::AXIS_W-1:0]         lateral_axis,
   input  logic [fgc_pkg::AXIS_W-1:0]         forward_axis,
   output fgc_pkg::item_type                  item_out
);
   import fgc_pkg::*;

   logic signed [COORD_W-1:0] bite_ff;
   logic signed [BASE_W-1:0]  base_ff, base_in;
   logic signed [SEL_W-1:0]   chosen_ff;
   logic                      collided_ff, saw_ff;
   logic signed [COORD_W-1:0] fwd, lat;
   logic                      below_bite, below_base, known;

   function automatic logic signed [COORD_W-1:0] pick_axis(
      input logic [AXIS_W-1:0] sel,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z);
      logic signed [COORD_W-1:0] r;
      case (sel)
         AXIS_X:  r = x;
         AXIS_Y:  r = y;
         default: r = z;
      endcase
      return r;
   endfunction

   always_comb begin
      fwd        = pick_axis(forward_axis, coord_x, coord_y, coord_z);
      lat        = pick_axis(lateral_axis, coord_x, coord_y, coord_z);
      below_bite = fwd < bite_ff;
      below_base = BASE_W'(fwd) < base_ff;
      base_in    = BASE_W'(bite_depth) - signed'({2'b00, palm_depth});
      known      = (action == ACT_BEGIN) || (action == ACT_POINT) || (action == ACT_END);

      item_out          = '0;
      item_out.valid    = accept && known;
      item_out.kind     = action_type'(action);
      item_out.mark     = below_bite && !below_base;
      item_out.dl       = D_W'(lat);
      item_out.dr       = D_W'(lat);
      item_out.collided = collided_ff;
      item_out.saw      = saw_ff;
      item_out.chosen   = chosen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bite_ff     <= '0;
         base_ff     <= '0;
         chosen_ff   <= SEL_ALL;
         collided_ff <= 1'b0;
         saw_ff      <= 1'b0;
      end else if (accept) begin
         case (action)
            ACT_BEGIN: begin
               bite_ff     <= bite_depth;
               base_ff     <= base_in;
               chosen_ff   <= slot_select;
               collided_ff <= 1'b0;
               saw_ff      <= 1'b0;
            end
            ACT_POINT: begin
               if (below_bite) begin
                  saw_ff <= 1'b1;
                  if (below_base) begin
                     collided_ff <= 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/fgc_cell.sv
// One chain cell: holds a left and a right slot occupancy bit and passes the
// transaction on with the lateral offsets moved by one placement step. Uses fgc_pkg.
module fgc_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [fgc_pkg::CFG_W-1:0] tine_width,
   input  logic [fgc_pkg::CFG_W-1:0] placement_step,
   input  fgc_pkg::item_type        item_in,
   output fgc_pkg::item_type        item_out
);
   import fgc_pkg::*;

   item_type              item_ff;
   logic                  occ_l_ff, occ_r_ff;
   logic signed [D_W-1:0] width_ext, step_ext;
   logic                  hit_l, hit_r;

   always_comb begin
      width_ext = signed'({{(D_W-CFG_W){1'b0}}, tine_width});
      step_ext  = signed'({{(D_W-CFG_W){1'b0}}, placement_step});
      hit_l     = (item_ff.dl > 0) && (item_ff.dl < width_ext);
      hit_r     = (item_ff.dr > 0) && (item_ff.dr < width_ext);

      item_out       = item_ff;
      item_out.dl    = item_ff.dl + step_ext;
      item_out.dr    = item_ff.dr - step_ext;
      item_out.occ_l = {item_ff.occ_l[NUM_PLACEMENTS-2:0], occ_l_ff};
      item_out.occ_r = {occ_r_ff, item_ff.occ_r[NUM_PLACEMENTS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_l_ff <= 1'b0;
         occ_r_ff <= 1'b0;
      end else if (en && item_ff.valid) begin
         case (item_ff.kind)
            ACT_BEGIN: begin
               occ_l_ff <= 1'b0;
               occ_r_ff <= 1'b0;
            end
            ACT_POINT: begin
               if (item_ff.mark) begin
                  occ_l_ff <= occ_l_ff | hit_l;
                  occ_r_ff <= occ_r_ff | hit_r;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/fgc_checker.sv
// Port-level checks for finger_gap_collision_check, bound to the top level.
// Depends on fgc_pkg and finger_gap_collision_check_defines.svh.
`include "finger_gap_collision_check_defines.svh"

module fgc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [fgc_pkg::RSP_W-1:0]      rsp_tdata
);
   import fgc_pkg::*;

   logic [FINGER_W-1:0] finger;
   logic [HAND_W-1:0]   hand;
   logic                basecol, empty;
   logic                rsp_stall, pair_ok;

   assign finger    = rsp_tdata[FINGER_W-1:0];
   assign hand      = rsp_tdata[FINGER_W+HAND_W-1:FINGER_W];
   assign basecol   = rsp_tdata[FINGER_W+HAND_W];
   assign empty     = rsp_tdata[FINGER_W+HAND_W+1];
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign pair_ok   = (hand & ~(finger[HAND_W-1:0] & finger[2*HAND_W-1:HAND_W])) == '0;

   // a stalled result holds
   `FGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // input side is never blocked while the output register is empty
   `FGC_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // a free pair needs both of its fingers free
   `FGC_ASSERT_NOW(a_pair_fingers, clock, reset, rsp_tvalid, pair_ok)

   // collision or empty region leaves no free slot
   `FGC_ASSERT_NOW(a_blocked_zero, clock, reset, rsp_tvalid && (basecol || empty), (finger == '0) && (hand == '0))

endmodule

bind finger_gap_collision_check fgc_checker u_fgc_checker (.*);
